// ----- rtl/generational_handle_table_unit_assert.svh -----
// Assertion macros for the generational handle table unit.
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define GHT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ght_pkg.sv -----
// Shared types and constants of the generational handle table.
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;

  localparam int unsigned HandleW    = 32;
  localparam int unsigned OwnerW     = 31;
  localparam int unsigned DescW      = 20;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_WAIT   = 2'd2,
    CMD_CLOSE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_STALE  = 2'd2,
    ST_CLOSED = 2'd3
  } status_e;

  typedef enum logic {
    BK_READ,
    BK_EXEC
  } bk_state_e;

  // One classified command waiting for the execution unit.
  typedef struct packed {
    cmd_e                cmd;
    logic                hi_bad;   // handle has bits set above the generation field
    logic [HandleW-1:0]  handle;
    logic [OwnerW-1:0]   owner;
    logic [DescW-1:0]    wdesc;
    logic [DescW-1:0]    rdesc;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/ght_front.sv -----
// Command intake: accepts a command and classifies it for the queue.
`timescale 1ns / 1ps
`default_nettype none
module ght_front #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned GEN_WIDTH  = 24
) (
  input  wire logic                      start,
  input  wire logic [1:0]                command_i,
  input  wire logic [31:0]               handle_i,
  input  wire logic [30:0]               owner_id_i,
  input  wire logic [19:0]               write_desc_i,
  input  wire logic [19:0]               read_desc_i,
  input  wire logic                      full_i,
  output logic                           busy,
  output logic                           push_o,
  output ght_pkg::item_t                 item_o
);
  import ght_pkg::*;

  localparam int unsigned SlotBits = $clog2(SLOT_COUNT);
  localparam int unsigned GenRoom  = HandleW - SlotBits;
  localparam int unsigned GenKeep  = (GEN_WIDTH < GenRoom) ? GEN_WIDTH : GenRoom;
  localparam logic [HandleW:0] LowOnes =
      ((HandleW+1)'(1) << (SlotBits + GenKeep)) - (HandleW+1)'(1);

  cmd_e cmd;

  assign cmd    = cmd_e'(command_i);
  assign busy   = full_i;
  assign push_o = start && !full_i;

  always_comb begin
    item_o.cmd    = cmd;
    // Bits beyond slot index plus generation can never match a minted handle.
    item_o.hi_bad = (cmd != CMD_ALLOC) && (|(handle_i & ~LowOnes[HandleW-1:0]));
    item_o.handle = handle_i;
    item_o.owner  = owner_id_i;
    item_o.wdesc  = write_desc_i;
    item_o.rdesc  = read_desc_i;
  end

endmodule
`default_nettype wire

// ----- rtl/ght_queue.sv -----
// Short command queue between intake and execution unit.
`timescale 1ns / 1ps
`default_nettype none
module ght_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  ght_pkg::item_t      item_i,
  input  wire logic           pop_i,
  output ght_pkg::item_t      item_o,
  output logic                full_o,
  output logic                empty_o
);
  import ght_pkg::*;

  item_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ght_back.sv -----
// Execution unit: slot memories, free list and result register.
`timescale 1ns / 1ps
`default_nettype none
module ght_back #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned GEN_WIDTH  = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  ght_pkg::item_t      item_i,
  output logic                pop_o,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [31:0]         new_handle_o,
  output logic [30:0]         entry_owner_o,
  output logic [19:0]         entry_write_desc_o,
  output logic [19:0]         entry_read_desc_o
);
  import ght_pkg::*;

  localparam int unsigned SlotBits = $clog2(SLOT_COUNT);
  localparam int unsigned GenRoom  = HandleW - SlotBits;
  localparam int unsigned GenKeep  = (GEN_WIDTH < GenRoom) ? GEN_WIDTH : GenRoom;
  localparam int unsigned CntW     = SlotBits + 1;

  // Slot storage, single port: read in BK_READ, written in BK_EXEC.
  logic [GenKeep-1:0]  gen_mem    [SLOT_COUNT];
  logic                live_mem   [SLOT_COUNT];
  logic [OwnerW-1:0]   owner_mem  [SLOT_COUNT];
  logic [DescW-1:0]    wdesc_mem  [SLOT_COUNT];
  logic [DescW-1:0]    rdesc_mem  [SLOT_COUNT];
  logic [SlotBits-1:0] link_mem   [SLOT_COUNT];

  logic [GenKeep-1:0]  gen_rd_q;
  logic                live_rd_q;
  logic [OwnerW-1:0]   owner_rd_q;
  logic [DescW-1:0]    wdesc_rd_q;
  logic [DescW-1:0]    rdesc_rd_q;
  logic [SlotBits-1:0] link_rd_q;

  bk_state_e           state_q, state_d;
  item_t               cur_q, cur_d;
  logic [SlotBits-1:0] addr_q, addr_d;
  logic [SlotBits-1:0] head_q, head_d;
  logic [CntW-1:0]     free_cnt_q, free_cnt_d;
  logic [CntW-1:0]     fresh_q, fresh_d;

  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [HandleW-1:0]  nh_q, nh_d;
  logic [OwnerW-1:0]   own_q, own_d;
  logic [DescW-1:0]    wd_q, wd_d;
  logic [DescW-1:0]    rd_q, rd_d;

  logic                rd_en;
  logic [SlotBits-1:0] rd_addr;
  logic                slot_we;
  logic                rel_we;
  logic [GenKeep-1:0]  new_gen;
  logic                handle_ok;

  assign handle_ok = ({1'b0, addr_q} < fresh_q) && !cur_q.hi_bad &&
                     (cur_q.handle[SlotBits +: GenKeep] == gen_rd_q);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    addr_d     = addr_q;
    head_d     = head_q;
    free_cnt_d = free_cnt_q;
    fresh_d    = fresh_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    slot_we    = 1'b0;
    rel_we     = 1'b0;
    new_gen    = '0;
    done_d     = 1'b0;
    status_d   = ST_OK;
    nh_d       = '0;
    own_d      = '0;
    wd_d       = '0;
    rd_d       = '0;
    unique case (state_q)
      BK_READ: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          rd_en = 1'b1;
          cur_d = item_i;
          if (item_i.cmd == CMD_ALLOC) begin
            rd_addr = (free_cnt_q != '0) ? head_q : fresh_q[SlotBits-1:0];
          end else begin
            rd_addr = item_i.handle[SlotBits-1:0];
          end
          addr_d  = rd_addr;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_d = BK_READ;
        done_d  = 1'b1;
        unique case (cur_q.cmd) inside
          CMD_ALLOC: begin
            if (free_cnt_q != '0) begin
              // Reuse the most recently freed slot under a new generation.
              new_gen    = gen_rd_q + 1'b1;
              head_d     = link_rd_q;
              free_cnt_d = free_cnt_q - 1'b1;
              slot_we    = 1'b1;
            end else if (fresh_q < CntW'(SLOT_COUNT)) begin
              fresh_d = fresh_q + 1'b1;
              slot_we = 1'b1;
            end else begin
              status_d = ST_FULL;
            end
            if (slot_we) begin
              nh_d[SlotBits-1:0]        = addr_q;
              nh_d[SlotBits +: GenKeep] = new_gen;
            end
          end
          CMD_LOOKUP, CMD_WAIT, CMD_CLOSE: begin
            if (!handle_ok) begin
              status_d = ST_STALE;
            end else if (!live_rd_q) begin
              status_d = (cur_q.cmd == CMD_CLOSE) ? ST_CLOSED : ST_STALE;
            end else begin
              own_d = owner_rd_q;
              if (cur_q.cmd == CMD_LOOKUP) begin
                wd_d = wdesc_rd_q;
                rd_d = rdesc_rd_q;
              end else begin
                rel_we     = 1'b1;
                head_d     = addr_q;
                free_cnt_d = free_cnt_q + 1'b1;
              end
            end
          end
          default: begin
            status_d = ST_STALE;
          end
        endcase
      end
      default: begin
        state_d = BK_READ;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_READ;
      head_q     <= '0;
      free_cnt_q <= '0;
      fresh_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      free_cnt_q <= free_cnt_d;
      fresh_q    <= fresh_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    addr_q <= addr_d;
    if (done_d) begin
      status_q <= status_d;
      nh_q     <= nh_d;
      own_q    <= own_d;
      wd_q     <= wd_d;
      rd_q     <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      gen_rd_q   <= gen_mem[rd_addr];
      live_rd_q  <= live_mem[rd_addr];
      owner_rd_q <= owner_mem[rd_addr];
      wdesc_rd_q <= wdesc_mem[rd_addr];
      rdesc_rd_q <= rdesc_mem[rd_addr];
      link_rd_q  <= link_mem[rd_addr];
    end
    if (slot_we) begin
      gen_mem[addr_q]   <= new_gen;
      live_mem[addr_q]  <= 1'b1;
      owner_mem[addr_q] <= cur_q.owner;
      wdesc_mem[addr_q] <= cur_q.wdesc;
      rdesc_mem[addr_q] <= cur_q.rdesc;
    end
    if (rel_we) begin
      live_mem[addr_q] <= 1'b0;
      link_mem[addr_q] <= head_q;
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign new_handle_o       = nh_q;
  assign entry_owner_o      = own_q;
  assign entry_write_desc_o = wd_q;
  assign entry_read_desc_o  = rd_q;

endmodule
`default_nettype wire

// ----- rtl/generational_handle_table_unit.sv -----
// Top level of the generational handle table unit.
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_table_unit_assert.svh"
// Generational handle table. A command is taken when start is high and busy
// is low; up to two commands wait in a queue, and busy is high while it is
// full. The execution unit handles each command in state BK_READ, which reads
// the slot and free-link memories, then in state BK_EXEC, which writes them
// back, so it takes a new command only after finishing the last. Each result
// shows on the result ports for a single cycle with done_o high; the receiver
// cannot stall, so results must be captured in that cycle. Handles hold the
// slot index in the low $clog2(SLOT_COUNT) bits and the generation above.
// Slot memories need no clearing after reset.
module generational_handle_table_unit #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned GEN_WIDTH  = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   command_i,
  input  wire logic [31:0]  handle_i,
  input  wire logic [30:0]  owner_id_i,
  input  wire logic [19:0]  write_desc_i,
  input  wire logic [19:0]  read_desc_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [31:0]       new_handle_o,
  output logic [30:0]       entry_owner_o,
  output logic [19:0]       entry_write_desc_o,
  output logic [19:0]       entry_read_desc_o
);
  import ght_pkg::*;

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;
  item_t in_item;
  item_t q_item;

  ght_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_WIDTH  (GEN_WIDTH)
  ) u_front (
    .start        (start),
    .command_i    (command_i),
    .handle_i     (handle_i),
    .owner_id_i   (owner_id_i),
    .write_desc_i (write_desc_i),
    .read_desc_i  (read_desc_i),
    .full_i       (q_full),
    .busy         (busy),
    .push_o       (push),
    .item_o       (in_item)
  );

  ght_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ght_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_WIDTH  (GEN_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (q_empty),
    .item_i             (q_item),
    .pop_o              (pop),
    .done_o             (done_o),
    .status_o           (status_o),
    .new_handle_o       (new_handle_o),
    .entry_owner_o      (entry_owner_o),
    .entry_write_desc_o (entry_write_desc_o),
    .entry_read_desc_o  (entry_read_desc_o)
  );

  // Each command passes through a read state and a write state, so results never come back to back.
  `GHT_ASSERT_NEXT(a_done_spaced, done_o, !done_o, "results on consecutive cycles")
  // A transfer into the unit must land in the queue.
  `GHT_ASSERT_NEXT(a_accept_queued, start && !busy, !q_empty, "accepted command lost")
  // Failed or non-allocating commands never mint a handle.
  `GHT_ASSERT_IMPLIES(a_no_handle_on_fail, done_o && (status_o != ST_OK), new_handle_o == '0, "handle minted on failure")

endmodule
`default_nettype wire
